### hw/rtl/psif_pkg.sv
// Package with the shared constants and types of the pair sum index finder.
`default_nettype none
package psif_pkg;
    localparam int MAX_ITEMS = 256;
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W = 32;
    localparam int POS_W = 8;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [POS_W-1:0] pos_t;
endpackage
`default_nettype wire

### hw/rtl/psif_if.sv
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none
interface psif_in_if import psif_pkg::*; ();
    logic valid;
    logic ready;
    val_t value;
    logic first_of_set;
    logic last_of_set;
    modport source (output valid, value, first_of_set, last_of_set, input ready);
    modport sink (input valid, value, first_of_set, last_of_set, output ready);
endinterface

interface psif_out_if import psif_pkg::*; ();
    logic valid;
    logic ready;
    logic found;
    pos_t earlier_index;
    pos_t later_index;
    logic capacity_exceeded;
    modport source (output valid, found, earlier_index, later_index, capacity_exceeded,
                    input ready);
    modport sink (input valid, found, earlier_index, later_index, capacity_exceeded,
                  output ready);
endinterface

interface psif_cfg_if import psif_pkg::*; ();
    logic valid;
    logic ready;
    val_t data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/psif_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module psif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/pair_sum_index_finder_unit.sv
// Pair sum index finder: scans the stored values of a set for a partner of each item.
// The stored entries of the set are read newest first, one per scan step, and the scan
// stops at the first match or after the oldest entry; an empty table ends it with no read.
// A new item is taken only in the idle state, once the scan of the last one is over; items
// of an answered set are taken with no scan. A result still waiting holds the end of a scan.
// Reset clears the target, the fill count and the flags at once; the value RAM needs none.
`default_nettype none
module pair_sum_index_finder_unit import psif_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    psif_in_if.sink     in_ch,
    psif_out_if.source  out_ch,
    psif_cfg_if.sink    cfg
);
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SCAN = 1'b1;

    logic [0:0]       state_reg;
    val_t             target_reg;
    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic             ovf_reg;
    val_t             value_reg;
    logic             last_reg;
    logic             empty_reg;
    logic [VAL_W:0]   need_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic             found_reg;
    pos_t             earlier_reg;
    pos_t             later_reg;
    logic             cap_reg;

    logic [IDX_W-1:0] raddr;
    val_t             rdata;
    logic             we;
    logic             accept;
    logic             hit;
    logic             finish;
    logic             step;
    logic             result_set;
    logic             out_free;
    logic             room;
    logic [CNT_W-1:0] count_eff;
    logic             done_eff;
    logic             ovf_eff;

    assign cfg.ready = (state_reg == ST_IDLE);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign room = (count_reg < CNT_W'(MAX_ITEMS));

    // A new set starts from an empty table.
    assign count_eff = in_ch.first_of_set ? '0 : count_reg;
    assign done_eff = in_ch.first_of_set ? 1'b0 : done_reg;
    assign ovf_eff = in_ch.first_of_set ? 1'b0 : ovf_reg;

    // The newest entry is read first so the first match is the most recent one.
    assign hit = !empty_reg && ({rdata[VAL_W-1], rdata} == need_reg);
    assign finish = (state_reg == ST_SCAN) && out_free
                    && (hit || empty_reg || idx_reg == '0);
    assign step = (state_reg == ST_SCAN) && !hit && !empty_reg && (idx_reg != '0);
    assign result_set = finish && (hit || last_reg);
    assign we = finish && !hit && room;

    always_comb
    begin
        raddr = idx_reg;
        if (accept)
        begin
            raddr = IDX_W'(count_eff - 1'b1);
        end
        else if (step)
        begin
            raddr = idx_reg - 1'b1;
        end
    end

    psif_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (IDX_W'(count_reg)),
        .wdata (value_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && !result_set)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                target_reg <= cfg.data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_eff;
                        done_reg  <= done_eff;
                        ovf_reg   <= ovf_eff;
                        if (!done_eff)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                        if (hit)
                        begin
                            out_valid_reg <= 1'b1;
                            done_reg      <= 1'b1;
                        end
                        else
                        begin
                            if (room)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                            if (last_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                done_reg      <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload and result registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= in_ch.value;
            last_reg  <= in_ch.last_of_set;
            empty_reg <= (count_eff == '0);
            need_reg  <= {target_reg[VAL_W-1], target_reg}
                         - {in_ch.value[VAL_W-1], in_ch.value};
            idx_reg   <= IDX_W'(count_eff - 1'b1);
        end
        else if (step)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (finish)
        begin
            found_reg   <= hit;
            earlier_reg <= hit ? POS_W'(idx_reg) : '0;
            later_reg   <= hit ? POS_W'(count_reg) : '0;
            cap_reg     <= ovf_reg || (!hit && !room);
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.found             = found_reg;
    assign out_ch.earlier_index     = earlier_reg;
    assign out_ch.later_index       = later_reg;
    assign out_ch.capacity_exceeded = cap_reg;
endmodule
`default_nettype wire

### sim/psif_tb_if.sv
// Testbench package with the input item and result item types of the pair sum index finder.
`default_nettype none
package psif_tb_pkg;
    import psif_pkg::*;

    typedef struct {
        val_t value;
        logic first_of_set;
        logic last_of_set;
    } set_item_t;

    typedef struct {
        logic found;
        pos_t earlier_index;
        pos_t later_index;
        logic capacity_exceeded;
    } pair_answer_t;
endpackage
`default_nettype wire

### sim/tb.sv
// Self-checking testbench of the pair sum index finder: streamed sets against a predictor.
`default_nettype none
module tb;
    import psif_pkg::*;
    import psif_tb_pkg::*;

    localparam int IDLE_MAX = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = MAX_ITEMS + 20;

    logic clk;
    logic rst_n;

    psif_in_if in_ch();
    psif_out_if out_ch();
    psif_cfg_if cfg();

    pair_sum_index_finder_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg(cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state.
    val_t seen_tbl[MAX_ITEMS];
    bit valid_tbl[MAX_ITEMS];
    int fill_pos;
    bit answered;
    bit spilled;
    val_t target_cfg;

    set_item_t pending_items[$];
    pair_answer_t expected_answers[$];
    int failures = 0;
    int watchdog = 0;
    bit sender_hold;
    bit cfg_busy;

    function automatic void clear_set();
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            valid_tbl[i] = 1'b0;
        end
        fill_pos = 0;
        answered = 1'b0;
        spilled = 1'b0;
    endfunction

    function automatic void predict_pair(set_item_t it);
        bit hit;
        int partner;
        longint want;
        pair_answer_t ans;
        hit = 1'b0;
        partner = 0;
        if (it.first_of_set)
        begin
            clear_set();
        end
        if (answered)
        begin
            return;
        end
        want = longint'(target_cfg) - longint'(it.value);
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            if (valid_tbl[i] && longint'(seen_tbl[i]) == want)
            begin
                hit = 1'b1;
                partner = i;
            end
        end
        if (hit)
        begin
            ans.found = 1'b1;
            ans.earlier_index = pos_t'(partner);
            ans.later_index = pos_t'(fill_pos);
            ans.capacity_exceeded = spilled;
            expected_answers = {expected_answers, ans};
            answered = 1'b1;
            return;
        end
        if (fill_pos < MAX_ITEMS)
        begin
            seen_tbl[fill_pos] = it.value;
            valid_tbl[fill_pos] = 1'b1;
            fill_pos++;
        end
        else
        begin
            spilled = 1'b1;
        end
        if (it.last_of_set)
        begin
            ans.found = 1'b0;
            ans.earlier_index = '0;
            ans.later_index = '0;
            ans.capacity_exceeded = spilled;
            expected_answers = {expected_answers, ans};
            answered = 1'b1;
        end
    endfunction

    function automatic val_t pick_value();
        case ($urandom_range(0, 5))
            0: return val_t'(32'h8000_0000);
            1: return val_t'(32'h7fff_ffff);
            2: return val_t'($urandom);
            default: return val_t'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic void add_item(val_t v, bit f, bit l);
        set_item_t it;
        it.value = v;
        it.first_of_set = f;
        it.last_of_set = l;
        pending_items = {pending_items, it};
    endfunction

    // A set with random content, often holding a pair that sums to the target.
    function automatic void add_set(int len, val_t tgt);
        int a;
        int b;
        val_t x;
        a = $urandom_range(0, len - 1);
        b = $urandom_range(0, len - 1);
        x = pick_value();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) != 0 && i == a)
            begin
                add_item(x, i == 0, i == len - 1);
            end
            else if (i == b && b != a)
            begin
                add_item(tgt - x, i == 0, i == len - 1);
            end
            else
            begin
                add_item(pick_value(), i == 0, i == len - 1);
            end
        end
    endfunction

    // Driver: one item at a time with a random gap before each.
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
            in_ch.first_of_set <= 1'b0;
            in_ch.last_of_set <= 1'b0;
            gap_left <= $urandom_range(0, IDLE_MAX);
            clear_set();
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            predict_pair(pending_items.pop_front());
            in_ch.valid <= 1'b0;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
        end
        else if (pending_items.size() > 0 && !sender_hold && !cfg_busy)
        begin
            in_ch.valid <= 1'b1;
            in_ch.value <= pending_items[0].value;
            in_ch.first_of_set <= pending_items[0].first_of_set;
            in_ch.last_of_set <= pending_items[0].last_of_set;
        end
    end

    // Monitor: random stalls on the result side, field-wise compare.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        pair_answer_t exp_ans;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: result expected none actual found=%0b", $time,
                             out_ch.found);
                    failures++;
                end
                else
                begin
                    exp_ans = expected_answers.pop_front();
                    if (exp_ans.found !== out_ch.found)
                    begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 exp_ans.found, out_ch.found);
                        failures++;
                    end
                    if (exp_ans.earlier_index !== out_ch.earlier_index)
                    begin
                        $display("%0t: earlier_index expected %0d actual %0d", $time,
                                 exp_ans.earlier_index, out_ch.earlier_index);
                        failures++;
                    end
                    if (exp_ans.later_index !== out_ch.later_index)
                    begin
                        $display("%0t: later_index expected %0d actual %0d", $time,
                                 exp_ans.later_index, out_ch.later_index);
                        failures++;
                    end
                    if (exp_ans.capacity_exceeded !== out_ch.capacity_exceeded)
                    begin
                        $display("%0t: capacity_exceeded expected %0b actual %0b", $time,
                                 exp_ans.capacity_exceeded, out_ch.capacity_exceeded);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                out_ch.ready <= 1'b0;
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog counts cycles with no handshake on any channel while work is outstanding.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready)
            || (pending_items.size() == 0 && expected_answers.size() == 0 && !cfg_busy))
        begin
            watchdog <= 0;
        end
        else
        begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_answers.size() > 0 || in_ch.valid)
        begin
            @(posedge clk);
        end
        // Items without a result may still be scanning.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(val_t t);
        wait_idle();
        cfg_busy = 1'b1;
        cfg.valid <= 1'b1;
        cfg.data <= t;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        target_cfg = t;
        cfg_busy = 1'b0;
    endtask

    val_t targets[6];

    initial
    begin
        sender_hold = 1'b0;
        cfg_busy = 1'b0;
        target_cfg = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // Items before any first mark continue the empty set; target still zero.
        add_item(5, 1'b0, 1'b0);
        add_item(-5, 1'b0, 1'b0);
        add_item(1, 1'b0, 1'b1);
        // One-element set.
        add_item(0, 1'b1, 1'b1);
        // Duplicate partners: most recent position wins.
        add_item(3, 1'b1, 1'b0);
        add_item(3, 1'b0, 1'b0);
        add_item(-3, 1'b0, 1'b0);
        add_item(7, 1'b0, 1'b1);
        // Extremes: min + max = -1, not zero; then min + min needs exact sum.
        add_item(val_t'(32'h8000_0000), 1'b1, 1'b0);
        add_item(val_t'(32'h7fff_ffff), 1'b0, 1'b0);
        add_item(val_t'(32'h8000_0000), 1'b0, 1'b1);
        wait_idle();

        // Targets at the ends of the value range, matched by exact sums.
        write_target(val_t'(32'h7fff_ffff));
        add_item(val_t'(32'h7fff_ffff), 1'b1, 1'b0);
        add_item(0, 1'b0, 1'b0);
        add_item(val_t'(32'h8000_0000), 1'b0, 1'b0);
        add_item(-1, 1'b0, 1'b1);
        write_target(val_t'(32'h8000_0000));
        add_item(val_t'(32'h8000_0000), 1'b1, 1'b0);
        add_item(0, 1'b0, 1'b0);
        add_item(0, 1'b0, 1'b1);
        add_item(-1, 1'b1, 1'b0);
        add_item(val_t'(32'h8000_0001), 1'b0, 1'b1);

        // Capacity: a long set with distinct values that overflows, then a match.
        write_target(-1);
        for (int i = 0; i < MAX_ITEMS + 4; i++)
        begin
            add_item(val_t'(i * 2), i == 0, 1'b0);
        end
        add_item(-1 - 2 * 300, 1'b0, 1'b0);
        add_item(-1 - 2 * 17, 1'b0, 1'b1);
        for (int i = 0; i < MAX_ITEMS + 2; i++)
        begin
            add_item(val_t'(i * 2), i == 0, i == MAX_ITEMS + 1);
        end
        wait_idle();

        targets[0] = 0;
        targets[1] = val_t'(32'h7fff_ffff);
        targets[2] = val_t'(32'h8000_0000);
        targets[3] = -1;
        targets[4] = val_t'($urandom);
        targets[5] = val_t'($urandom_range(0, 20)) - 10;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_target(targets[ph]);
            for (int s = 0; s < 12; s++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: loose items without proper marks.
                    add_item(pick_value(), $urandom_range(0, 1), $urandom_range(0, 1));
                end
                else
                begin
                    add_set($urandom_range(1, 10), targets[ph]);
                end
            end
            if (ph == 2)
            begin
                // Hold the sender until every result is in.
                while (pending_items.size() > 0 || in_ch.valid)
                begin
                    @(posedge clk);
                end
                sender_hold = 1'b1;
                while (expected_answers.size() > 0)
                begin
                    @(posedge clk);
                end
                sender_hold = 1'b0;
            end
        end
        wait_idle();

        if (failures == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/psif_pkg.sv
hw/rtl/psif_if.sv
hw/rtl/psif_ram.sv
hw/rtl/pair_sum_index_finder_unit.sv
sim/psif_tb_if.sv
sim/tb.sv
